[rtl/core/fba_pkg.sv]
`default_nettype none

package fba_pkg;

  // Field widths fixed by the request and result formats.
  localparam int OP_W    = 3;
  localparam int INDEX_W = 12;
  localparam int RUN_W   = 13;
  localparam int TOTAL_W = 13;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'h1000;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC_ONE = 3'd0,
    OP_ALLOC_RUN = 3'd1,
    OP_MARK      = 3'd2,
    OP_FREE      = 3'd3,
    OP_TEST      = 3'd4,
    OP_COUNT     = 3'd5
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_MARK    = 6'b000100,
    ST_RMW_RD  = 6'b001000,
    ST_RMW_WR  = 6'b010000,
    ST_RECOUNT = 6'b100000
  } state_e;

endpackage

`default_nettype wire

[rtl/core/fba_ram.sv]
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/fba_word_scan.sv]
`default_nettype none

// Looks at one bitmap word at a time: free frames at the bottom and at the top
// of the word, and the lowest start of a run of a short length inside it.
module fba_word_scan #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]         free_i,
  input  logic [$clog2(WORD_BITS)-1:0] len_i,
  input  logic                         short_i,
  output logic [$clog2(WORD_BITS):0]   low_free_o,
  output logic [$clog2(WORD_BITS):0]   high_free_o,
  output logic                         hit_o,
  output logic [$clog2(WORD_BITS)-1:0] hit_pos_o
);

  localparam int BW = $clog2(WORD_BITS);
  localparam int CW = BW + 1;

  // span[j][p] is set when frames p .. p + 2**j - 1 are all free.
  logic [WORD_BITS-1:0] span [BW];
  logic [WORD_BITS-1:0] starts;

  always_comb begin : run_detect
    logic [CW-1:0] off;
    off = '0;
    span[0] = free_i;
    for (int j = 1; j < BW; j++) begin
      span[j] = span[j-1] & (span[j-1] >> (1 << (j - 1)));
    end
    starts = '1;
    for (int j = BW - 1; j >= 0; j--) begin
      if (len_i[j]) begin
        starts = starts & (span[j] >> off);
        off    = off + CW'(1 << j);
      end
    end
  end

  always_comb begin
    low_free_o  = CW'(WORD_BITS);
    high_free_o = CW'(WORD_BITS);
    hit_pos_o   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!free_i[b]) begin
        low_free_o = CW'(b);
      end
      if (starts[b]) begin
        hit_pos_o = BW'(b);
      end
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!free_i[b]) begin
        high_free_o = CW'(WORD_BITS - 1 - b);
      end
    end
  end

  assign hit_o = short_i && (|starts);

endmodule

`default_nettype wire

[rtl/core/frame_bitmap_allocator.sv]
`default_nettype none

// Frame bitmap allocator: one usage bit per frame, held in a word-wide RAM.
// Requests enter on start/op_i/frame_index_i/run_length_i and are taken at a
// clock edge with start high and busy low. Every request gives exactly one
// result, shown for one cycle with done_o high; the receiver cannot stall it.
// How each request is handled:
//   count, unknown op codes, and mark/free/test of a frame past the limit: no RAM access.
//   mark, free, test: RAM read, then read-modify-write of one word.
//   alloc one / alloc run: a scan of the bitmap words, up to
//   ceil(limit / WORD_BITS) words, then a write to each word marked.
//   A run that cannot fit at all (zero or longer than the limit) fails without a scan.
// The word scan, one RAM read per cycle, sets the alloc time; with the
// defaults a full scan is 128 words.
// The frame_total register is written on the cfg channel while idle. Each
// transfer starts a recount sweep with busy high, so used_count_o follows
// the new limit.
// Reset makes all frames free through per-word valid flags (no sweep), sets
// frame_total to 4096 and the used count to zero. WORD_BITS is a power of 2.
module frame_bitmap_allocator import fba_pkg::*; #(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op_i,
  input  logic [INDEX_W-1:0] frame_index_i,
  input  logic [RUN_W-1:0]   run_length_i,
  output logic               done_o,
  output logic [INDEX_W-1:0] result_frame_o,
  output logic               found_o,
  output logic               frame_was_used_o,
  output logic [TOTAL_W-1:0] used_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [TOTAL_W-1:0] cfg_frame_total_i
);

  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int NW_RAW     = BIT_W + ADDR_W + 1;
  localparam int NW         = (NW_RAW > TOTAL_W) ? NW_RAW : TOTAL_W;

  localparam logic [NW-1:0] MAX_N  = NW'(MAX_FRAMES);
  localparam logic [NW-1:0] WORD_N = NW'(WORD_BITS);

  state_e state_q, state_d;

  logic [TOTAL_W-1:0] total_q, total_d;
  logic [NW-1:0]      count_q, count_d;
  logic [ADDR_W:0]    ptr_q, ptr_d;
  logic               proc_v_q, proc_v_d;
  logic [ADDR_W-1:0]  proc_addr_q, proc_addr_d;
  logic [NW-1:0]      streak_q, streak_d;
  logic [NW-1:0]      run_start_q, run_start_d;
  logic [NW-1:0]      len_q, len_d;
  logic [NW-1:0]      start_q, start_d;
  logic [NW-1:0]      end_q, end_d;
  op_e                op_q, op_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [WORD_COUNT-1:0] valid_q;
  logic               rd_valid_q;

  logic               done_q, done_d;
  logic [INDEX_W-1:0] res_frame_q, res_frame_d;
  logic               found_q, found_d;
  logic               was_q, was_d;

  logic [NW-1:0]          limit;
  logic [NW-1:0]          nwords;
  logic [ADDR_W:0]        ptr_end;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [WORD_BITS-1:0]   wdata;
  logic [WORD_BITS-1:0]   rdata;
  logic [WORD_BITS-1:0]   word;
  logic [NW-1:0]          base;
  logic [NW-1:0]          rem_full;
  logic [WORD_BITS-1:0]   lim_mask;
  logic [WORD_BITS-1:0]   free_bits;
  logic [BIT_W:0]         low_free;
  logic [BIT_W:0]         high_free;
  logic                   hit;
  logic [BIT_W-1:0]       hit_pos;
  logic                   len_short;
  logic [ADDR_W-1:0]      start_word;
  logic [ADDR_W-1:0]      end_word;
  logic [BIT_W-1:0]       mark_lo;
  logic [BIT_W-1:0]       mark_hi;
  logic [WORD_BITS-1:0]   mark_mask;
  logic [WORD_BITS-1:0]   bit_mask;
  logic [NW-1:0]          idx_ext;
  logic [NW-1:0]          req_len;
  logic [NW-1:0]          cand;
  logic [NW-1:0]          hit_start;
  logic                   accept;
  logic                   cfg_fire;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign accept      = start && !busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign limit  = (NW'(total_q) > MAX_N) ? MAX_N : NW'(total_q);
  assign nwords = (limit + NW'(WORD_BITS - 1)) >> BIT_W;

  assign start_word = start_q[BIT_W +: ADDR_W];
  assign end_word   = end_q[BIT_W +: ADDR_W];
  assign rd_addr    = ptr_q[ADDR_W-1:0];

  // A word never written since reset reads as all free.
  assign word = rd_valid_q ? rdata : '0;

  // Frames at or past the limit count as used.
  assign base     = NW'({proc_addr_q, {BIT_W{1'b0}}});
  assign rem_full = limit - base;
  assign lim_mask = (limit >= base + WORD_N) ? '1 : ~({WORD_BITS{1'b1}} << rem_full[BIT_W-1:0]);
  assign free_bits = ~word & lim_mask;

  assign len_short = (len_q < WORD_N);
  assign cand      = (streak_q == '0) ? base : run_start_q;
  assign hit_start = base + NW'(hit_pos);

  assign mark_lo   = (proc_addr_q == start_word) ? start_q[BIT_W-1:0] : '0;
  assign mark_hi   = (proc_addr_q == end_word) ? end_q[BIT_W-1:0] : '1;
  assign mark_mask = ({WORD_BITS{1'b1}} << mark_lo) &
                     ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mark_hi));
  assign bit_mask  = WORD_BITS'(1) << bit_q;

  assign idx_ext = NW'(frame_index_i);
  assign req_len = (op_e'(op_i) == OP_ALLOC_ONE) ? NW'(1) : NW'(run_length_i);

  fba_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_fba_word_scan (
    .free_i      (free_bits),
    .len_i       (len_q[BIT_W-1:0]),
    .short_i     (len_short),
    .low_free_o  (low_free),
    .high_free_o (high_free),
    .hit_o       (hit),
    .hit_pos_o   (hit_pos)
  );

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_fba_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (state_q)
      ST_MARK: ptr_end = {1'b0, end_word} + (ADDR_W + 1)'(1);
      default: ptr_end = nwords[ADDR_W:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    proc_v_d    = 1'b0;
    proc_addr_d = proc_addr_q;
    streak_d    = streak_q;
    run_start_d = run_start_q;
    len_d       = len_q;
    start_d     = start_q;
    end_d       = end_q;
    op_d        = op_q;
    bit_d       = bit_q;
    done_d      = 1'b0;
    res_frame_d = res_frame_q;
    found_d     = found_q;
    was_d       = was_q;
    rd_en       = 1'b0;
    we          = 1'b0;
    waddr       = proc_addr_q;
    wdata       = word | mark_mask;

    // Sweeping states read one word per cycle; the data is handled in the following cycle.
    if ((state_q == ST_SCAN || state_q == ST_MARK || state_q == ST_RECOUNT) &&
        (ptr_q < ptr_end)) begin
      rd_en       = 1'b1;
      ptr_d       = ptr_q + (ADDR_W + 1)'(1);
      proc_v_d    = 1'b1;
      proc_addr_d = ptr_q[ADDR_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = op_e'(op_i);
          case (op_e'(op_i))
            OP_ALLOC_ONE, OP_ALLOC_RUN: begin
              if (req_len == '0 || req_len > limit) begin
                done_d      = 1'b1;
                res_frame_d = '0;
                found_d     = 1'b0;
                was_d       = 1'b0;
              end else begin
                len_d    = req_len;
                ptr_d    = '0;
                streak_d = '0;
                state_d  = ST_SCAN;
              end
            end
            OP_MARK, OP_FREE, OP_TEST: begin
              res_frame_d = frame_index_i;
              if (idx_ext < limit) begin
                ptr_d   = {1'b0, idx_ext[BIT_W +: ADDR_W]};
                bit_d   = idx_ext[BIT_W-1:0];
                state_d = ST_RMW_RD;
              end else begin
                done_d  = 1'b1;
                found_d = 1'b0;
                was_d   = 1'b1;
              end
            end
            default: begin
              done_d      = 1'b1;
              res_frame_d = '0;
              found_d     = 1'b0;
              was_d       = 1'b0;
            end
          endcase
        end else if (cfg_fire) begin
          total_d = cfg_frame_total_i;
          count_d = '0;
          ptr_d   = '0;
          state_d = ST_RECOUNT;
        end
      end

      ST_SCAN: begin
        if (proc_v_q) begin
          // A free stretch carried from lower words wins over one inside this word.
          if (streak_q + NW'(low_free) >= len_q) begin
            start_d  = cand;
            end_d    = cand + len_q - NW'(1);
            ptr_d    = {1'b0, cand[BIT_W +: ADDR_W]};
            proc_v_d = 1'b0;
            state_d  = ST_MARK;
          end else if (hit) begin
            start_d  = hit_start;
            end_d    = hit_start + len_q - NW'(1);
            ptr_d    = {1'b0, proc_addr_q};
            proc_v_d = 1'b0;
            state_d  = ST_MARK;
          end else if (&free_bits) begin
            streak_d    = streak_q + WORD_N;
            run_start_d = cand;
          end else begin
            streak_d    = NW'(high_free);
            run_start_d = base + WORD_N - NW'(high_free);
          end
        end else if (ptr_q >= ptr_end) begin
          done_d      = 1'b1;
          res_frame_d = '0;
          found_d     = 1'b0;
          was_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      ST_MARK: begin
        if (proc_v_q) begin
          we    = 1'b1;
          waddr = proc_addr_q;
          wdata = word | mark_mask;
          if (proc_addr_q == end_word) begin
            count_d     = count_q + len_q;
            done_d      = 1'b1;
            res_frame_d = start_q[INDEX_W-1:0];
            found_d     = 1'b1;
            was_d       = 1'b0;
            proc_v_d    = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end

      ST_RMW_RD: begin
        rd_en   = 1'b1;
        state_d = ST_RMW_WR;
      end

      ST_RMW_WR: begin
        waddr = ptr_q[ADDR_W-1:0];
        was_d = word[bit_q];
        case (op_q)
          OP_MARK: begin
            we      = 1'b1;
            wdata   = word | bit_mask;
            count_d = count_q + NW'(!word[bit_q]);
          end
          OP_FREE: begin
            we      = 1'b1;
            wdata   = word & ~bit_mask;
            count_d = count_q - NW'(word[bit_q]);
          end
          default: begin
            we = 1'b0;
          end
        endcase
        done_d  = 1'b1;
        found_d = 1'b1;
        state_d = ST_IDLE;
      end

      ST_RECOUNT: begin
        if (proc_v_q) begin
          count_d = count_q + NW'($countones(word & lim_mask));
        end else if (ptr_q >= ptr_end) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      total_q  <= TOTAL_RESET;
      count_q  <= '0;
      ptr_q    <= '0;
      proc_v_q <= 1'b0;
      valid_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      proc_v_q <= proc_v_d;
      done_q   <= done_d;
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    proc_addr_q <= proc_addr_d;
    streak_q    <= streak_d;
    run_start_q <= run_start_d;
    len_q       <= len_d;
    start_q     <= start_d;
    end_q       <= end_d;
    op_q        <= op_d;
    bit_q       <= bit_d;
    res_frame_q <= res_frame_d;
    found_q     <= found_d;
    was_q       <= was_d;
    if (rd_en) begin
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  assign done_o           = done_q;
  assign result_frame_o   = res_frame_q;
  assign found_o          = found_q;
  assign frame_was_used_o = was_q;
  assign used_count_o     = count_q[TOTAL_W-1:0];

endmodule

`default_nettype wire

[rtl/core/fba_checker.sv]
`default_nettype none

module fba_checker import fba_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_i,
  input logic [OP_W-1:0]    op_i,
  input logic               cfg_valid_i,
  input logic               cfg_ready_i,
  input logic               done_i,
  input logic               found_i,
  input logic               frame_was_used_i,
  input logic [INDEX_W-1:0] result_frame_i
);

  // A result is only shown once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result strobe while busy");

  // Each register write starts the recount sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_i) |=> busy_i)
    else $error("no recount after configuration transfer");

  // Requests take priority over configuration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i |-> (!busy_i && !start_i))
    else $error("configuration ready while a request is pending");

  // A count request answers in the next cycle with only the count filled in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && op_i == OP_COUNT) |=>
      (done_i && !found_i && !frame_was_used_i && result_frame_i == '0))
    else $error("count request result wrong");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start),
  .busy_i           (busy),
  .op_i             (op_i),
  .cfg_valid_i      (cfg_valid_i),
  .cfg_ready_i      (cfg_ready_o),
  .done_i           (done_o),
  .found_i          (found_o),
  .frame_was_used_i (frame_was_used_o),
  .result_frame_i   (result_frame_o)
);

`default_nettype wire

[tb/sv/tb_frame_bitmap_allocator.sv]
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator;
  import fba_pkg::*;

  localparam int FRAME_CAP        = 4096;
  localparam int RANDOM_PER_PHASE = 73;
  localparam int TAIL_CYCLES      = 300;

  // Op codes the block does not define; they must leave the bitmap alone.
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [INDEX_W-1:0] frame;
    logic               found;
    logic               was_used;
    logic [TOTAL_W-1:0] used;
  } alloc_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    op_i;
  logic [INDEX_W-1:0] frame_index_i;
  logic [RUN_W-1:0]   run_length_i;
  logic               done_o;
  logic [INDEX_W-1:0] result_frame_o;
  logic               found_o;
  logic               frame_was_used_o;
  logic [TOTAL_W-1:0] used_count_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [TOTAL_W-1:0] cfg_frame_total_i;

  // Shadow copy of the allocator state.
  bit                 usage_map [FRAME_CAP];
  logic [TOTAL_W-1:0] frame_total_q;
  alloc_result_t      pending_results [$];
  int                 error_count;

  frame_bitmap_allocator i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .frame_index_i    (frame_index_i),
    .run_length_i     (run_length_i),
    .done_o           (done_o),
    .result_frame_o   (result_frame_o),
    .found_o          (found_o),
    .frame_was_used_o (frame_was_used_o),
    .used_count_o     (used_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_frame_total_i(cfg_frame_total_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #15ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int frame_limit();
    return (frame_total_q > FRAME_CAP) ? FRAME_CAP : int'(frame_total_q);
  endfunction

  // Applies one request to the shadow bitmap and returns the result it should give.
  function automatic alloc_result_t apply_request(input logic [OP_W-1:0] op,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [RUN_W-1:0] len);
    alloc_result_t res;
    int lim;
    int want;
    int streak;
    int first;
    int used;
    lim   = frame_limit();
    res   = '0;
    first = -1;
    case (op)
      OP_ALLOC_ONE, OP_ALLOC_RUN: begin
        want = (op == OP_ALLOC_ONE) ? 1 : int'(len);
        if (want != 0 && want <= lim) begin
          streak = 0;
          for (int f = 0; f < lim && first < 0; f++) begin
            if (usage_map[f]) begin
              streak = 0;
            end else begin
              streak++;
              if (streak == want) first = f + 1 - want;
            end
          end
        end
        if (first >= 0) begin
          for (int k = 0; k < want; k++) usage_map[first + k] = 1'b1;
          res.frame = first[INDEX_W-1:0];
          res.found = 1'b1;
        end
      end
      OP_MARK, OP_FREE, OP_TEST: begin
        res.frame = idx;
        if (int'(idx) < lim) begin
          res.found    = 1'b1;
          res.was_used = usage_map[idx];
          if (op == OP_MARK) usage_map[idx] = 1'b1;
          else if (op == OP_FREE) usage_map[idx] = 1'b0;
        end else begin
          // Frames past the limit read as used and are never touched.
          res.was_used = 1'b1;
        end
      end
      default: ;
    endcase
    used = 0;
    for (int f = 0; f < lim; f++) used += usage_map[f];
    res.used = used[TOTAL_W-1:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                      input logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    alloc_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual frame %0d",
                 $time, result_frame_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_frame", TOTAL_W'(want.frame), TOTAL_W'(result_frame_o));
        check_field("found", TOTAL_W'(want.found), TOTAL_W'(found_o));
        check_field("frame_was_used", TOTAL_W'(want.was_used), TOTAL_W'(frame_was_used_o));
        check_field("used_count", want.used, used_count_o);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Start stays high after a transfer so that back-to-back requests need no
  // second assignment in one time step; every other path lowers it first.
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                               input logic [RUN_W-1:0] len, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start         <= 1'b1;
    op_i          <= op;
    frame_index_i <= idx;
    run_length_i  <= len;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(apply_request(op, idx, len));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_frame_total(input logic [TOTAL_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_frame_total_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    frame_total_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_single_frame_ops();
    issue_request(OP_COUNT, 12'd0, 13'd0, pick_gap());
    issue_request(OP_MARK, 12'd0, 13'd0, pick_gap());
    issue_request(OP_TEST, 12'd0, 13'd0, pick_gap());
    issue_request(OP_MARK, 12'd0, 13'd0, pick_gap());
    issue_request(OP_FREE, 12'd0, 13'd0, pick_gap());
    issue_request(OP_FREE, 12'd0, 13'd0, pick_gap());
    issue_request(OP_MARK, 12'd4095, 13'd8191, pick_gap());
    issue_request(OP_TEST, 12'd4095, 13'd0, pick_gap());
    issue_request(OP_RSVD_6, 12'd4095, 13'd8191, pick_gap());
    issue_request(OP_RSVD_7, 12'd1, 13'd1, pick_gap());
  endtask

  task automatic test_run_allocation();
    issue_request(OP_ALLOC_ONE, 12'd0, 13'd0, pick_gap());
    issue_request(OP_ALLOC_ONE, 12'd0, 13'd0, pick_gap());
    issue_request(OP_FREE, 12'd0, 13'd0, pick_gap());
    issue_request(OP_ALLOC_RUN, 12'd0, 13'd0, pick_gap());
    issue_request(OP_ALLOC_RUN, 12'd0, 13'd8191, pick_gap());
    issue_request(OP_ALLOC_RUN, 12'd0, 13'd4097, pick_gap());
    issue_request(OP_ALLOC_RUN, 12'd0, 13'd3, pick_gap());
    issue_request(OP_ALLOC_ONE, 12'd0, 13'd0, pick_gap());
    issue_request(OP_ALLOC_RUN, 12'd0, 13'd4096, pick_gap());
  endtask

  task automatic test_frame_limit();
    write_frame_total(13'd40);
    issue_request(OP_TEST, 12'd40, 13'd0, pick_gap());
    issue_request(OP_FREE, 12'd4095, 13'd0, pick_gap());
    issue_request(OP_ALLOC_RUN, 12'd0, 13'd40, pick_gap());
    issue_request(OP_ALLOC_RUN, 12'd0, 13'd35, pick_gap());
    issue_request(OP_ALLOC_ONE, 12'd0, 13'd0, pick_gap());
    // Lowering the limit hides the used frames above it without clearing them.
    write_frame_total(13'd0);
    issue_request(OP_TEST, 12'd0, 13'd0, pick_gap());
    write_frame_total(13'd8191);
    issue_request(OP_COUNT, 12'd0, 13'd0, pick_gap());
  endtask

  task automatic test_random_traffic();
    logic [TOTAL_W-1:0] totals [10];
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic [RUN_W-1:0]   len;
    int                 lim;
    int                 roll;
    bit                 bursty;
    totals = '{13'd4096, 13'd37, 13'd8191, 13'd100, 13'd1,
               13'd300, 13'd0, 13'd64, 13'd0, 13'd4095};
    totals[8] = TOTAL_W'($urandom_range(0, 8191));
    for (int p = 0; p < 10; p++) begin
      write_frame_total(totals[p]);
      lim    = frame_limit();
      bursty = (p % 3 == 1);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 0 && n == 40) drain_results();
        roll = $urandom_range(0, 99);
        if (roll < 28) op = OP_ALLOC_ONE;
        else if (roll < 43) op = OP_ALLOC_RUN;
        else if (roll < 55) op = OP_MARK;
        else if (roll < 80) op = OP_FREE;
        else if (roll < 90) op = OP_TEST;
        else if (roll < 96) op = OP_COUNT;
        else op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;

        roll = $urandom_range(0, 99);
        if (roll < 80 && lim > 0) idx = INDEX_W'($urandom_range(0, lim - 1));
        else if (roll < 90) idx = INDEX_W'(lim + $urandom_range(0, 3));
        else idx = INDEX_W'($urandom_range(0, 4095));

        roll = $urandom_range(0, 99);
        if (roll < 60 && lim > 0) len = RUN_W'($urandom_range(1, (lim < 16) ? lim : 16));
        else if (roll < 75 && lim > 0) len = RUN_W'($urandom_range(1, lim));
        else if (roll < 82) len = '0;
        else if (roll < 90) len = RUN_W'(lim + $urandom_range(1, 8));
        else len = RUN_W'($urandom_range(0, 8191));

        issue_request(op, idx, len, bursty ? 0 : pick_gap());
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    start             = 1'b0;
    op_i              = OP_COUNT;
    frame_index_i     = '0;
    run_length_i      = '0;
    cfg_valid_i       = 1'b0;
    cfg_frame_total_i = '0;
    frame_total_q     = TOTAL_RESET;
    error_count       = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_frame_ops();
    test_run_allocation();
    test_frame_limit();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
